>>> rtl/icwt_pkg.sv
// ----------------------------------------------------------------------------
// icwt_pkg
// shared types, register offsets and field masks of the interrupt controller
// with prescaled timers
// ----------------------------------------------------------------------------
`default_nettype none

package icwt_pkg;

    // defaults for the top-level parameters
    localparam int DEF_TIMER_COUNT       = 2;
    localparam int DEF_FIRST_TIMER_LEVEL = 8;

    // action codes of an input transaction
    typedef enum logic [1:0] {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_TICK  = 2'd2,
        ACT_ACK   = 2'd3
    } action_t;

    // register offsets
    localparam logic [7:0] OFS_CACHE      = 8'h14;
    localparam logic [7:0] OFS_CONFIG     = 8'h24;
    localparam logic [7:0] OFS_PRE_COUNT  = 8'h60;
    localparam logic [7:0] OFS_PRE_RELOAD = 8'h64;
    localparam logic [7:0] OFS_MASK       = 8'h90;
    localparam logic [7:0] OFS_PENDING    = 8'h94;
    localparam logic [7:0] OFS_FORCE      = 8'h98;
    localparam logic [7:0] OFS_CLEAR      = 8'h9C;

    // timer window 0x40..0x5f: offset[7:5], timer index in offset[4]
    localparam logic [2:0] TIMER_WINDOW = 3'b010;
    localparam logic [3:0] TMR_VALUE    = 4'h0;
    localparam logic [3:0] TMR_RELOAD   = 4'h4;
    localparam logic [3:0] TMR_CONTROL  = 4'h8;

    // timer control bits
    localparam int         CTL_ENABLE    = 0;
    localparam int         CTL_RELOAD    = 1;
    localparam int         CTL_LOAD      = 2;
    localparam logic [3:0] CTL_KEEP_MASK = 4'hb;

    // field masks and fixed words
    localparam logic [16:0] CACHE_MASK   = 17'h1000f;
    localparam logic [15:0] MASK_WR_MASK = 16'h7ffe;
    localparam logic [15:0] LEVEL_MASK   = 16'hfffe;
    localparam logic [31:0] CONFIG_WORD  = 32'h0070_0310;
    localparam logic [15:0] PRE_RESET    = 16'hffff;
    localparam logic [31:0] TIMER0_RESET = 32'hffff_ffff;
    localparam logic [31:0] TIMERN_RESET = 32'h0000_0000;

    // per-timer strobes for one accepted transaction
    typedef struct packed {
        logic wr_value;
        logic wr_reload;
        logic wr_control;
        logic tick;
    } icwt_timer_cmd_t;

    // interrupt register strobes for one accepted transaction
    typedef struct packed {
        logic wr_mask;
        logic wr_force;
        logic wr_clear;
        logic ack;
    } icwt_irq_cmd_t;

endpackage

`default_nettype wire

>>> rtl/icwt_timer.sv
// ----------------------------------------------------------------------------
// icwt_timer
// one 32-bit down-counting timer with reload value and control register
// ----------------------------------------------------------------------------
`default_nettype none

module icwt_timer
    import icwt_pkg::*;
#(
    parameter logic [31:0] RESET_VALUE = TIMERN_RESET
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire icwt_timer_cmd_t cmd,
    input  wire logic [31:0]     data,
    output logic [31:0]          value,
    output logic [31:0]          reload,
    output logic [3:0]           control,
    output logic                 wrap
);

    logic [31:0] value_reg, value_next;
    logic [31:0] reload_reg, reload_next;
    logic [3:0]  control_reg, control_next;

    always_comb
    begin
        value_next   = value_reg;
        reload_next  = reload_reg;
        control_next = control_reg;
        wrap         = 1'b0;
        if (cmd.wr_value)
        begin
            value_next = data;
        end
        if (cmd.wr_reload)
        begin
            reload_next = data;
        end
        if (cmd.wr_control)
        begin
            // load bit copies the reload value at once and is not kept
            if (data[CTL_LOAD])
            begin
                value_next = reload_reg;
            end
            control_next = data[3:0] & CTL_KEEP_MASK;
        end
        if (cmd.tick && control_reg[CTL_ENABLE])
        begin
            value_next = value_reg - 32'd1;
            if (value_reg == 32'd0)
            begin
                wrap = 1'b1;
                if (control_reg[CTL_RELOAD])
                begin
                    value_next = reload_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg   <= RESET_VALUE;
            reload_reg  <= RESET_VALUE;
            control_reg <= '0;
        end
        else
        begin
            value_reg   <= value_next;
            reload_reg  <= reload_next;
            control_reg <= control_next;
        end
    end

    assign value   = value_reg;
    assign reload  = reload_reg;
    assign control = control_reg;

endmodule

`default_nettype wire

>>> rtl/icwt_irq.sv
// ----------------------------------------------------------------------------
// icwt_irq
// pending, force and mask words with priority encoder over the next state
// ----------------------------------------------------------------------------
`default_nettype none

module icwt_irq
    import icwt_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire icwt_irq_cmd_t cmd,
    input  wire logic [15:0]   data,
    input  wire logic [3:0]    ack_level,
    input  wire logic [15:0]   set_bits,
    output logic [15:0]        pending,
    output logic [15:0]        forced,
    output logic [15:0]        mask,
    output logic [3:0]         level_next
);

    logic [15:0] pending_reg, pending_next;
    logic [15:0] forced_reg, forced_next;
    logic [15:0] mask_reg, mask_next;
    logic [15:0] ack_bit;
    logic [15:0] active;

    assign ack_bit = 16'd1 << ack_level;

    always_comb
    begin
        pending_next = pending_reg | set_bits;
        forced_next  = forced_reg;
        mask_next    = mask_reg;
        if (cmd.wr_mask)
        begin
            mask_next = data & MASK_WR_MASK;
        end
        if (cmd.wr_force)
        begin
            forced_next = data & LEVEL_MASK;
        end
        if (cmd.wr_clear)
        begin
            pending_next = pending_reg & ~data & LEVEL_MASK;
        end
        if (cmd.ack)
        begin
            // force bit first, pending bit only when no force is set
            if ((forced_reg & ack_bit) != 16'd0)
            begin
                forced_next = forced_reg & ~ack_bit;
            end
            else
            begin
                pending_next = pending_reg & ~ack_bit;
            end
        end
    end

    // highest unmasked level after this transaction
    assign active = (pending_next | forced_next) & mask_next & LEVEL_MASK;

    always_comb
    begin
        level_next = 4'd0;
        for (int l = 1; l < 16; l++)
        begin
            if (active[l])
            begin
                level_next = 4'(l);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            forced_reg  <= '0;
            mask_reg    <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
            forced_reg  <= forced_next;
            mask_reg    <= mask_next;
        end
    end

    assign pending = pending_reg;
    assign forced  = forced_reg;
    assign mask    = mask_reg;

endmodule

`default_nettype wire

>>> rtl/irq_controller_with_timers.sv
// ----------------------------------------------------------------------------
// irq_controller_with_timers
// 15-level interrupt controller and prescaled down-counting timers as one
// bus-mapped register block
// ----------------------------------------------------------------------------
//
//  channel   handshake            payload
//  -------   ------------------   --------------------------------------------
//  input     in_valid / in_stall   action, reg_offset, write_data, ack_level
//  output    out_valid / out_stall read_data, irq_level
//
//  one transaction is accepted per cycle while in_stall is low; its result
//  is loaded into the output register at the edge that accepts it
//  all register state changes at the edge that accepts the transaction
//  in_stall is raised only while a result is held and out_stall is high
//  reset sets every register but read_data and irq_level to its reset value
//
`default_nettype none

module irq_controller_with_timers
    import icwt_pkg::*;
#(
    parameter int TIMER_COUNT       = DEF_TIMER_COUNT,
    parameter int FIRST_TIMER_LEVEL = DEF_FIRST_TIMER_LEVEL
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  action,
    input  wire logic [7:0]  reg_offset,
    input  wire logic [31:0] write_data,
    input  wire logic [3:0]  ack_level,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      read_data,
    output logic [3:0]       irq_level
);

    action_t act;
    logic    accept;
    logic    wr;
    logic    in_window;

    // prescaler
    logic [15:0] pre_count_reg, pre_count_next;
    logic [15:0] pre_reload_reg, pre_reload_next;
    logic        pre_zero;
    logic        tick_go;
    logic        timer_tick;

    logic [16:0] cache_reg, cache_next;

    // timers
    logic [31:0] tmr_value   [TIMER_COUNT];
    logic [31:0] tmr_reload  [TIMER_COUNT];
    logic [3:0]  tmr_control [TIMER_COUNT];
    logic [TIMER_COUNT-1:0] tmr_wrap;

    // interrupt block
    icwt_irq_cmd_t irq_cmd;
    logic [15:0]   set_bits;
    logic [15:0]   pending;
    logic [15:0]   forced;
    logic [15:0]   mask;
    logic [3:0]    level_next;

    // result
    logic [31:0] rd_data;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] read_data_reg;
    logic [3:0]  irq_level_reg;

    assign act      = action_t'(action);
    // a held result that is not being taken blocks the next transaction
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign wr       = accept && (act == ACT_WRITE);

    assign in_window = (reg_offset[7:5] == TIMER_WINDOW);

    // prescaler: counts down per tick, timers step on the tick that finds zero
    assign pre_zero   = (pre_count_reg == 16'd0);
    assign tick_go    = accept && (act == ACT_TICK);
    assign timer_tick = tick_go && pre_zero;

    always_comb
    begin
        pre_count_next  = pre_count_reg;
        pre_reload_next = pre_reload_reg;
        cache_next      = cache_reg;
        if (tick_go)
        begin
            pre_count_next = pre_zero ? pre_reload_reg : (pre_count_reg - 16'd1);
        end
        // a reload write does not restart the running count
        if (wr && (reg_offset == OFS_PRE_RELOAD))
        begin
            pre_reload_next = write_data[15:0];
        end
        if (wr && (reg_offset == OFS_CACHE))
        begin
            cache_next = write_data[16:0] & CACHE_MASK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_count_reg  <= PRE_RESET;
            pre_reload_reg <= PRE_RESET;
            cache_reg      <= '0;
        end
        else
        begin
            pre_count_reg  <= pre_count_next;
            pre_reload_reg <= pre_reload_next;
            cache_reg      <= cache_next;
        end
    end

    // one timer per instance, offset[4] picks the timer inside the window
    for (genvar i = 0; i < TIMER_COUNT; i++)
    begin : g_timer
        icwt_timer_cmd_t tcmd;
        logic            tsel;

        assign tsel            = wr && in_window && (reg_offset[4] == 1'(i));
        assign tcmd.wr_value   = tsel && (reg_offset[3:0] == TMR_VALUE);
        assign tcmd.wr_reload  = tsel && (reg_offset[3:0] == TMR_RELOAD);
        assign tcmd.wr_control = tsel && (reg_offset[3:0] == TMR_CONTROL);
        assign tcmd.tick       = timer_tick;

        icwt_timer #(
            .RESET_VALUE((i == 0) ? TIMER0_RESET : TIMERN_RESET)
        ) u_timer (
            .clk     (clk),
            .rst_n   (rst_n),
            .cmd     (tcmd),
            .data    (write_data),
            .value   (tmr_value[i]),
            .reload  (tmr_reload[i]),
            .control (tmr_control[i]),
            .wrap    (tmr_wrap[i])
        );
    end

    // a wrapping timer raises its own level
    always_comb
    begin
        set_bits = '0;
        for (int i = 0; i < TIMER_COUNT; i++)
        begin
            if (tmr_wrap[i])
            begin
                set_bits[4'(FIRST_TIMER_LEVEL + i)] = 1'b1;
            end
        end
    end

    assign irq_cmd.wr_mask  = wr && (reg_offset == OFS_MASK);
    assign irq_cmd.wr_force = wr && (reg_offset == OFS_FORCE);
    assign irq_cmd.wr_clear = wr && (reg_offset == OFS_CLEAR);
    assign irq_cmd.ack      = accept && (act == ACT_ACK);

    icwt_irq u_irq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (irq_cmd),
        .data       (write_data[15:0]),
        .ack_level  (ack_level),
        .set_bits   (set_bits),
        .pending    (pending),
        .forced     (forced),
        .mask       (mask),
        .level_next (level_next)
    );

    // read mux, zero for every other action and for unmapped offsets
    always_comb
    begin
        rd_data = 32'd0;
        if (act == ACT_READ)
        begin
            if (in_window)
            begin
                for (int i = 0; i < TIMER_COUNT; i++)
                begin
                    if (reg_offset[4] == 1'(i))
                    begin
                        case (reg_offset[3:0])
                            TMR_VALUE:   rd_data = tmr_value[i];
                            TMR_RELOAD:  rd_data = tmr_reload[i];
                            TMR_CONTROL: rd_data = {28'd0, tmr_control[i]};
                            default:     rd_data = 32'd0;
                        endcase
                    end
                end
            end
            else
            begin
                case (reg_offset)
                    OFS_CACHE:      rd_data = {15'd0, cache_reg};
                    OFS_CONFIG:     rd_data = CONFIG_WORD;
                    OFS_PRE_COUNT:  rd_data = {16'd0, pre_count_reg};
                    OFS_PRE_RELOAD: rd_data = {16'd0, pre_reload_reg};
                    OFS_MASK:       rd_data = {16'd0, mask};
                    OFS_PENDING:    rd_data = {16'd0, pending};
                    OFS_FORCE:      rd_data = {16'd0, forced};
                    default:        rd_data = 32'd0;
                endcase
            end
        end
    end

    // output register: loads on accept, empties when the result is taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_data_reg <= rd_data;
            irq_level_reg <= level_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;
    assign irq_level = irq_level_reg;

    // only reads return data
    a_nonread_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (act != ACT_READ)) |=> (read_data == 32'd0))
        else $error("non-read transaction returned data");

    // mask bit 15 can never be set, so level 15 is never driven out
    a_no_level15: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (irq_level != 4'd15))
        else $error("level 15 driven out");

    // a tick on a nonzero prescaler counts it down by one
    a_pre_step: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_go && !pre_zero) |=> (pre_count_reg == ($past(pre_count_reg) - 16'd1)))
        else $error("prescaler did not count down");

    // a transaction accepted under a held result would have overwritten it
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !accept)
        else $error("result overwritten while stalled");

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the interrupt controller with prescaled timers:
// a shadow copy of the register block predicts read_data and irq_level for
// every transaction, and a monitor compares each result in order
// ----------------------------------------------------------------------------

module tb_top;

    import icwt_pkg::*;

    // block configuration under test
    localparam int NUM_TIMERS       = DEF_TIMER_COUNT;
    localparam int TIMER_BASE_LEVEL = DEF_FIRST_TIMER_LEVEL;

    // offsets that decode to fixed zero reads
    localparam logic [7:0] OFS_POWER_DOWN  = 8'h18;
    localparam logic [7:0] OFS_UART_DATA   = 8'h70;
    localparam logic [7:0] OFS_UART_STATUS = 8'h74;

    // bench timing
    localparam int HOLD_CYCLES   = 60;    // long receiver hold-off
    localparam int HANG_LIMIT    = 1000;  // cycles with no transaction
    localparam int SETTLE_CYCLES = 8;     // quiet time after the last result

    typedef struct packed {
        logic [31:0] rdata;
        logic [3:0]  level;
    } response_t;

    // ------------------------------------------------------------------------
    // clock, reset and block ports; every input has a known value at time 0
    // ------------------------------------------------------------------------
    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    action_t     action     = ACT_READ;
    logic [7:0]  reg_offset = '0;
    logic [31:0] write_data = '0;
    logic [3:0]  ack_level  = '0;
    logic        out_valid;
    logic        out_stall  = 1'b0;
    logic [31:0] read_data;
    logic [3:0]  irq_level;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    irq_controller_with_timers #(
        .TIMER_COUNT       (NUM_TIMERS),
        .FIRST_TIMER_LEVEL (TIMER_BASE_LEVEL)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .reg_offset (reg_offset),
        .write_data (write_data),
        .ack_level  (ack_level),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_data  (read_data),
        .irq_level  (irq_level)
    );

    // ------------------------------------------------------------------------
    // shadow register state, at reset values
    // ------------------------------------------------------------------------
    logic [15:0] irq_pend   = '0;
    logic [15:0] irq_force  = '0;
    logic [15:0] irq_mask   = '0;
    logic [15:0] psc_reload = PRE_RESET;
    logic [15:0] psc_count  = PRE_RESET;
    logic [31:0] tmr_count  [NUM_TIMERS];
    logic [31:0] tmr_reload [NUM_TIMERS];
    logic [3:0]  tmr_ctl    [NUM_TIMERS];
    logic [16:0] cache_word = '0;

    initial
    begin
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            tmr_count[i]  = (i == 0) ? TIMER0_RESET : TIMERN_RESET;
            tmr_reload[i] = (i == 0) ? TIMER0_RESET : TIMERN_RESET;
            tmr_ctl[i]    = '0;
        end
    end

    // results owed by the block, oldest first
    response_t due_responses[$];

    // knobs shared by the sender and receiver processes
    int tx_gap_pct   = 0;
    int rx_stall_pct = 0;
    bit hold_off     = 1'b0;

    // run statistics
    int n_items    = 0;
    int n_ticks    = 0;
    int n_wraps    = 0;
    int n_results  = 0;
    int n_stalled  = 0;
    int mismatches = 0;

    // highest level with pending or forced set under the mask; level 15 can
    // never be unmasked and bit 0 is not a level
    function automatic logic [3:0] shadow_level();
        logic [15:0] live;
        live = (irq_pend | irq_force) & irq_mask & LEVEL_MASK;
        for (int l = 15; l > 0; l--)
        begin
            if (live[l])
                return 4'(l);
        end
        return 4'd0;
    endfunction

    // apply one transaction to the shadow registers and return the result
    // the block owes for it
    function automatic response_t shadow_access(action_t act, logic [7:0] ofs,
                                                logic [31:0] data, logic [3:0] lvl);
        response_t r;
        int        t;
        int        i;
        logic      in_timer;
        r.rdata  = '0;
        t        = ofs[4] ? 1 : 0;
        // timer window 0x40..0x5f; a timer that is not built decodes as unmapped
        in_timer = (ofs[7:5] == TIMER_WINDOW) && (t < NUM_TIMERS);
        case (act)
            ACT_READ:
            begin
                if (in_timer)
                begin
                    case (ofs[3:0])
                        TMR_VALUE:   r.rdata = tmr_count[t];
                        TMR_RELOAD:  r.rdata = tmr_reload[t];
                        TMR_CONTROL: r.rdata = {28'd0, tmr_ctl[t]};
                        default:     r.rdata = '0;
                    endcase
                end
                else
                begin
                    case (ofs)
                        OFS_CACHE:      r.rdata = {15'd0, cache_word};
                        OFS_CONFIG:     r.rdata = CONFIG_WORD;
                        OFS_PRE_COUNT:  r.rdata = {16'd0, psc_count};
                        OFS_PRE_RELOAD: r.rdata = {16'd0, psc_reload};
                        OFS_MASK:       r.rdata = {16'd0, irq_mask};
                        OFS_PENDING:    r.rdata = {16'd0, irq_pend};
                        OFS_FORCE:      r.rdata = {16'd0, irq_force};
                        default:        r.rdata = '0;
                    endcase
                end
            end
            ACT_WRITE:
            begin
                if (in_timer)
                begin
                    case (ofs[3:0])
                        TMR_VALUE:  tmr_count[t]  = data;
                        TMR_RELOAD: tmr_reload[t] = data;
                        TMR_CONTROL:
                        begin
                            // load strobe copies the reload value and is not kept
                            if (data[CTL_LOAD])
                                tmr_count[t] = tmr_reload[t];
                            tmr_ctl[t] = data[3:0] & CTL_KEEP_MASK;
                        end
                        default: ;
                    endcase
                end
                else
                begin
                    case (ofs)
                        OFS_CACHE:      cache_word = data[16:0] & CACHE_MASK;
                        OFS_PRE_RELOAD: psc_reload = data[15:0];
                        OFS_MASK:       irq_mask   = data[15:0] & MASK_WR_MASK;
                        OFS_FORCE:      irq_force  = data[15:0] & LEVEL_MASK;
                        OFS_CLEAR:      irq_pend   = irq_pend & ~data[15:0] & LEVEL_MASK;
                        default: ;
                    endcase
                end
            end
            ACT_TICK:
            begin
                // the prescaler reloads on the tick that finds it at zero, and
                // only that tick steps the enabled timers
                if (psc_count != 16'd0)
                    psc_count = psc_count - 16'd1;
                else
                begin
                    psc_count = psc_reload;
                    for (i = 0; i < NUM_TIMERS; i++)
                    begin
                        if (tmr_ctl[i][CTL_ENABLE])
                        begin
                            tmr_count[i] = tmr_count[i] - 32'd1;
                            if (tmr_count[i] == '1)
                            begin
                                irq_pend[(TIMER_BASE_LEVEL + i) % 16] = 1'b1;
                                n_wraps++;
                                if (tmr_ctl[i][CTL_RELOAD])
                                    tmr_count[i] = tmr_reload[i];
                            end
                        end
                    end
                end
            end
            default:
            begin
                // acknowledge takes the force bit first, else the pending bit
                if (irq_force[lvl])
                    irq_force[lvl] = 1'b0;
                else
                    irq_pend[lvl] = 1'b0;
            end
        endcase
        r.level = shadow_level();
        return r;
    endfunction

    // idle length: mostly short, in about one pick of ten a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 30);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [7:0] timer_ofs(int t, logic [3:0] field);
        return {TIMER_WINDOW, t[0], field};
    endfunction

    // mostly decoded registers, sometimes any offset at all
    function automatic logic [7:0] pick_offset();
        if ($urandom_range(0, 3) == 0)
            return 8'($urandom_range(0, 255));
        case ($urandom_range(0, 16))
            0:       return OFS_CACHE;
            1:       return OFS_POWER_DOWN;
            2:       return OFS_CONFIG;
            3:       return timer_ofs(0, TMR_VALUE);
            4:       return timer_ofs(0, TMR_RELOAD);
            5:       return timer_ofs(0, TMR_CONTROL);
            6:       return timer_ofs(1, TMR_VALUE);
            7:       return timer_ofs(1, TMR_RELOAD);
            8:       return timer_ofs(1, TMR_CONTROL);
            9:       return OFS_PRE_COUNT;
            10:      return OFS_PRE_RELOAD;
            11:      return OFS_UART_DATA;
            12:      return OFS_UART_STATUS;
            13:      return OFS_MASK;
            14:      return OFS_PENDING;
            15:      return OFS_FORCE;
            default: return OFS_CLEAR;
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        $display("mismatch at result %0d: %s got %h expected %h",
                 n_results, what, got, want);
    endtask

    // ------------------------------------------------------------------------
    // sender: entered and left at a falling edge; valid stays high across
    // back-to-back transactions and drops only for a gap
    // ------------------------------------------------------------------------
    task automatic send_item(action_t act, logic [7:0] ofs, logic [31:0] data,
                             logic [3:0] lvl);
        int gap;
        gap = 0;
        if ($urandom_range(0, 99) < tx_gap_pct)
            gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        action     <= act;
        reg_offset <= ofs;
        write_data <= data;
        ack_level  <= lvl;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // accepted at this edge: the shadow moves in the same order as the block
        due_responses.push_back(shadow_access(act, ofs, data, lvl));
        n_items++;
        if (act == ACT_TICK)
            n_ticks++;
        @(negedge clk);
    endtask

    // unused fields carry random noise
    task automatic send_read(logic [7:0] ofs);
        send_item(ACT_READ, ofs, $urandom, 4'($urandom));
    endtask

    task automatic send_write(logic [7:0] ofs, logic [31:0] data);
        send_item(ACT_WRITE, ofs, data, 4'($urandom));
    endtask

    task automatic send_tick();
        send_item(ACT_TICK, 8'($urandom), $urandom, 4'($urandom));
    endtask

    task automatic send_ack(logic [3:0] lvl);
        send_item(ACT_ACK, 8'($urandom), $urandom, lvl);
    endtask

    // ------------------------------------------------------------------------
    // receiver: random stall bursts, plus one long hold-off on request
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (hold_off)
            begin
                hold_off   = 1'b0;
                stall_left = HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end
            else if ($urandom_range(0, 99) < rx_stall_pct)
            begin
                stall_left = pick_gap() - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // result monitor: each accepted result against the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        response_t want;
        if (rst_n)
        begin
            if (in_valid && in_stall)
                n_stalled++;
            if (out_valid && !out_stall)
            begin
                n_results++;
                if (due_responses.size() == 0)
                    report_mismatch("result with no transaction waiting", read_data, '0);
                else
                begin
                    want = due_responses.pop_front();
                    if (read_data !== want.rdata)
                        report_mismatch("read_data", read_data, want.rdata);
                    if (irq_level !== want.level)
                        report_mismatch("irq_level", {28'd0, irq_level}, {28'd0, want.level});
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: ends the run when no transaction moves for too long
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < HANG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no transaction for %0d cycles", HANG_LIMIT);
        $display("tb_top NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // fixed words, write masks, ignored and unmapped offsets
    task automatic test_register_map();
        send_read(OFS_CONFIG);
        send_write(OFS_CACHE, 32'hffff_ffff);
        send_read(OFS_CACHE);
        send_write(OFS_PRE_COUNT, 32'd0);        // count is read only
        send_read(OFS_PRE_COUNT);
        send_write(OFS_POWER_DOWN, 32'hffff_ffff);
        send_read(OFS_POWER_DOWN);
        send_write(8'hff, 32'hffff_ffff);        // top of the offset range, unmapped
        send_read(8'hff);
        send_read(OFS_UART_DATA);
        send_read(timer_ofs(0, TMR_VALUE));      // timer 0 resets to all ones
    endtask

    // priority, force before pending on acknowledge, level 15 never unmasked
    task automatic test_irq_priority();
        send_write(OFS_MASK, 32'hffff_ffff);
        send_write(OFS_FORCE, 32'hffff_ffff);
        send_ack(4'd15);
        send_ack(4'd14);
        send_ack(4'd0);                          // level 0 acknowledge does nothing
        send_write(OFS_CLEAR, 32'hffff_ffff);
        send_write(OFS_FORCE, 32'd0);
    endtask

    // prescaler reload write does not restart the count; load strobe
    task automatic test_timer_setup();
        send_write(OFS_PRE_RELOAD, 32'hffff_ffff);
        send_read(OFS_PRE_RELOAD);
        send_write(OFS_PRE_RELOAD, 32'd2);
        send_read(OFS_PRE_COUNT);
        send_write(timer_ofs(0, TMR_VALUE), 32'd1);
        send_write(timer_ofs(0, TMR_RELOAD), 32'd5);
        send_write(timer_ofs(0, TMR_CONTROL), (32'd1 << CTL_ENABLE) | (32'd1 << CTL_RELOAD));
        send_write(timer_ofs(1, TMR_CONTROL), 32'hffff_ffff);
        send_read(timer_ofs(1, TMR_CONTROL));
    endtask

    // the prescaler leaves reset at full count and a reload write does not
    // restart it, so ticks here only count it down and the enabled timers
    // must hold their values
    task automatic test_prescaler_count();
        int i;
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        for (i = 0; i < 40; i++)
        begin
            send_tick();
            if (i % 8 == 7)
                send_read(OFS_PRE_COUNT);
        end
        send_read(OFS_PENDING);
        send_read(timer_ofs(0, TMR_VALUE));
        send_read(timer_ofs(1, TMR_VALUE));
    endtask

    // receiver holds off long while the sender keeps offering, so the
    // output register fills and the input stalls
    task automatic test_pressure();
        int i;
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        hold_off     = 1'b1;
        for (i = 0; i < 24; i++)
        begin
            if (i % 3 == 0)
                send_tick();
            else
                send_read(pick_offset());
        end
    endtask

    // mixed traffic: ticks, register accesses, interrupt service sequences
    // and reload probes, in stretches with different idling
    task automatic test_random_traffic(int count);
        int          stop_at;
        int          seg_left;
        int          kind;
        logic [7:0]  ofs;
        logic [31:0] data;
        logic [3:0]  lvl;
        stop_at  = n_items + count;
        seg_left = 0;
        while (n_items < stop_at)
        begin
            if (seg_left <= 0)
            begin
                seg_left = 100;
                case ($urandom_range(0, 3))
                    0:       tx_gap_pct = 0;
                    1:       tx_gap_pct = 5;
                    2:       tx_gap_pct = 20;
                    default: tx_gap_pct = 50;
                endcase
                case ($urandom_range(0, 3))
                    0:       rx_stall_pct = 0;
                    1:       rx_stall_pct = 5;
                    2:       rx_stall_pct = 20;
                    default: rx_stall_pct = 50;
                endcase
            end
            kind = $urandom_range(0, 99);
            if (kind < 35)
            begin
                send_tick();
                seg_left--;
            end
            else if (kind < 55)
            begin
                send_read(pick_offset());
                seg_left--;
            end
            else if (kind < 80)
            begin
                ofs  = pick_offset();
                data = $urandom;
                // small timer counts so wraps happen often
                if (ofs[7:5] == TIMER_WINDOW && ofs[3:0] != TMR_CONTROL
                    && $urandom_range(0, 3) != 0)
                    data = $urandom_range(0, 12);
                else if (ofs[7:5] == TIMER_WINDOW && ofs[3:0] == TMR_CONTROL
                         && $urandom_range(0, 3) != 0)
                    data[CTL_ENABLE] = 1'b1;
                // a large reload would park the timers for the rest of the run
                if (ofs == OFS_PRE_RELOAD)
                    data = $urandom_range(0, 3);
                // keep forced levels sparse so timer levels show through
                if (ofs == OFS_FORCE && $urandom_range(0, 1) == 0)
                    data = '0;
                send_write(ofs, data);
                seg_left--;
            end
            else if (kind < 88)
            begin
                // service: read pending, acknowledge the driven level, and sometimes clear it
                lvl = shadow_level();
                send_read(OFS_PENDING);
                send_ack(lvl);
                if ($urandom_range(0, 1) == 0)
                    send_write(OFS_CLEAR, 32'd1 << lvl);
                seg_left -= 3;
            end
            else if (kind < 94)
            begin
                send_ack(4'($urandom_range(0, 15)));
                seg_left--;
            end
            else
            begin
                // wide reload written and read back, then made short again
                // before any tick can reach it
                send_write(OFS_PRE_RELOAD, ($urandom_range(0, 3) == 0) ? 32'hffff_ffff : $urandom);
                send_read(OFS_PRE_RELOAD);
                send_write(OFS_PRE_RELOAD, $urandom_range(0, 3));
                seg_left -= 3;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_register_map();
        test_irq_priority();
        test_timer_setup();
        test_prescaler_count();
        test_pressure();
        test_random_traffic(1350);

        in_valid <= 1'b0;
        while (due_responses.size() != 0)
            @(posedge clk);
        // catch any stray result after the last one owed
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d transactions (%0d ticks, %0d timer wraps), %0d results checked",
                 n_items, n_ticks, n_wraps, n_results);
        $display("input held back in %0d cycles, %0d mismatches", n_stalled, mismatches);
        if (mismatches == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
